// ===== hdl/avwn_pkg.sv =====
// Package for the angle weighted vertex normal block.
// Holds action codes, fixed-point constants and the arithmetic unit handshake types.
// No dependencies.
package avwn_pkg;

	localparam logic [1:0] ACT_STORE = 2'd0;
	localparam logic [1:0] ACT_TRI   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [31:0] PI_Q30     = 32'd3373259426;
	localparam logic [29:0] H_LIMIT    = 30'h3000_0000;
	localparam int          ASIN_TERMS = 48;

	// Request to the shared divide / square root unit.
	typedef struct packed {
		logic        go;
		logic        is_sqrt;
		logic [63:0] num;
		logic [31:0] den;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} arith_rsp_t;

endpackage

// ===== hdl/angle_weighted_vertex_normals.sv =====
// Top level of the angle weighted vertex normal block.
// Depends on avwn_pkg, avwn_ram (position and accumulator stores) and avwn_arith.
//
// Items arrive as commands: a beat is taken when start is high and busy is low, and
// the receiver of results cannot stall, so a read result is shown on result_valid for
// exactly one cycle. A store is written as it is taken and leaves busy low. A read uses
// one square root and three divisions on the shared iterative unit, plus the
// normalising shift, which moves one bit a cycle. A read of a zero accumulator skips
// the unit and returns zeros, and a read of an index beyond the store returns zeros
// in the cycle after it is taken. For a non-degenerate triangle whose corners are all
// valid, each corner normalises both of its edges and takes 48 series terms of the
// arcsine, each with divisions by 2n+2 and 2n+3. Clear sweeps the accumulator store one
// entry per cycle over all VERTEX_DEPTH entries, and the same sweep runs after reset,
// during which busy is high. The flip register may be written at any idle time and
// takes effect on the next read.
module angle_weighted_vertex_normals
	import avwn_pkg::*;
#(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [9:0]         vertex_index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               result_valid,
	output logic [9:0]         out_index,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z
);

	localparam int AW = $clog2(VERTEX_DEPTH);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_OUT,
		S_TP, S_TX, S_TN, S_CE1, S_CE2, S_CE3,
		S_DOT, S_WSQ, S_HSQ, S_AX2, S_AP, S_ANG,
		S_AP0, S_AM, S_AW,
		S_U0, S_USH, S_USQ, S_ULN, S_UDV
	} state_t;

	state_t state_q, ret_q;
	logic   ph_q;
	logic [2:0] cnt_q;
	logic [5:0] term_q;
	logic [1:0] ci_q;
	logic [AW-1:0] clr_q;
	logic   flip_q;

	logic signed [23:0] p_q [3][3];
	logic [9:0]         idx_q [3];

	// Normalisation working set, shared by face normal, edges and reads.
	logic signed [51:0] vec_q [3];
	logic [51:0]        mag_q [3];
	logic               sgn_q [3];
	logic               frac30_q;
	logic               ok_q;
	logic [63:0]        sq_q;
	logic [31:0]        len_q;
	logic signed [31:0] uvo_q [3];

	logic signed [15:0] n_q [3];
	logic signed [31:0] u_q [3];
	logic signed [31:0] v_q [3];
	logic signed [63:0] dot_q;
	logic [29:0]        x2_q;
	logic [39:0]        pp_q;
	logic [31:0]        sum_q;
	logic [31:0]        ang_q;
	logic signed [17:0] d_q [3];
	logic [9:0]         rd_idx_q;

	logic               valid_q;
	logic [9:0]         oidx_q;
	logic signed [15:0] onx_q, ony_q, onz_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q;

	arith_req_t areq;
	arith_rsp_t arsp;

	logic          accept;
	logic          pos_we, pos_re, acc_we, acc_re;
	logic [AW-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
	logic [71:0]   pos_wdata, pos_rdata;
	logic [95:0]   acc_wdata, acc_rdata;

	logic [1:0]         c1, c2;
	logic signed [24:0] e1 [3];
	logic signed [24:0] e2 [3];
	logic signed [32:0] w_k;
	logic [51:0]        mmax;
	logic [1:0]         ka, kb;
	logic [32:0]        ang_a;
	logic [31:0]        q_mul;
	logic               tri_ok;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign tri_ok = (32'(corner_a) < VERTEX_DEPTH) && (32'(corner_b) < VERTEX_DEPTH)
		&& (32'(corner_c) < VERTEX_DEPTH);

	// Edges leaving the current corner towards the next two corners.
	always_comb begin
		case (ci_q)
			2'd0: begin c1 = 2'd1; c2 = 2'd2; end
			2'd1: begin c1 = 2'd2; c2 = 2'd0; end
			default: begin c1 = 2'd0; c2 = 2'd1; end
		endcase
		for (int k = 0; k < 3; k++) begin
			e1[k] = 25'(p_q[c1][k]) - 25'(p_q[ci_q][k]);
			e2[k] = 25'(p_q[c2][k]) - 25'(p_q[ci_q][k]);
		end
	end

	always_comb begin
		mmax = mag_q[0];
		if (mag_q[1] > mmax) mmax = mag_q[1];
		if (mag_q[2] > mmax) mmax = mag_q[2];
	end

	assign w_k = dot_q[63] ? 33'(v_q[cnt_q[1:0]]) + 33'(u_q[cnt_q[1:0]])
		: 33'(v_q[cnt_q[1:0]]) - 33'(u_q[cnt_q[1:0]]);

	assign ang_a = {sum_q, 1'b0};
	assign q_mul = 32'((mul_q + 66'sd536870912) >>> 30);

	// Operand pairs of the cross product terms.
	always_comb begin
		case (cnt_q)
			3'd0: begin ka = 2'd1; kb = 2'd2; end
			3'd1: begin ka = 2'd2; kb = 2'd1; end
			3'd2: begin ka = 2'd2; kb = 2'd0; end
			3'd3: begin ka = 2'd0; kb = 2'd2; end
			3'd4: begin ka = 2'd0; kb = 2'd1; end
			default: begin ka = 2'd1; kb = 2'd0; end
		endcase
	end

	// The one multiplier: operands follow the state, the product is registered.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TX: begin
				mul_a = 33'(e1[ka]);
				mul_b = 33'(e2[kb]);
			end
			S_USQ: begin
				mul_a = $signed({3'b0, mag_q[cnt_q[1:0]][29:0]});
				mul_b = $signed({3'b0, mag_q[cnt_q[1:0]][29:0]});
			end
			S_DOT: begin
				mul_a = 33'(u_q[cnt_q[1:0]]);
				mul_b = 33'(v_q[cnt_q[1:0]]);
			end
			S_WSQ: begin
				mul_a = w_k;
				mul_b = w_k;
			end
			S_AX2: begin
				mul_a = $signed({3'b0, pp_q[29:0]});
				mul_b = $signed({3'b0, pp_q[29:0]});
			end
			S_AP: begin
				mul_a = $signed({1'b0, pp_q[31:0]});
				mul_b = (cnt_q == 3'd0) ? $signed({3'b0, x2_q})
					: $signed(33'({term_q, 1'b1}));
			end
			S_AM: begin
				mul_a = n_q[cnt_q[1:0]][15] ? 33'(-n_q[cnt_q[1:0]]) : 33'(n_q[cnt_q[1:0]]);
				mul_b = $signed({1'b0, ang_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// Requests to the shared divide / square root unit.
	always_comb begin
		areq.go      = 1'b0;
		areq.is_sqrt = 1'b0;
		areq.num     = '0;
		areq.den     = '0;
		case (state_q)
			S_ULN, S_HSQ: begin
				areq.go      = !ph_q;
				areq.is_sqrt = 1'b1;
				areq.num     = sq_q;
			end
			S_UDV: begin
				areq.go  = !ph_q;
				areq.num = (64'(mag_q[cnt_q[1:0]][29:0]) << (frac30_q ? 30 : 14))
					+ 64'(len_q >> 1);
				areq.den = len_q;
			end
			S_AP: begin
				areq.go  = !ph_q && cnt_q[1];
				areq.num = 64'(pp_q);
				areq.den = 32'({term_q, 1'b0}) + (cnt_q[0] ? 32'd3 : 32'd2);
			end
			default: begin
				areq.go = 1'b0;
			end
		endcase
	end

	avwn_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	// Position store: {z, y, x}, written by store items only.
	assign pos_we    = accept && (action == ACT_STORE) && (32'(vertex_index) < VERTEX_DEPTH);
	assign pos_waddr = AW'(vertex_index);
	assign pos_wdata = {pos_z, pos_y, pos_x};
	assign pos_re    = (state_q == S_TP) && (cnt_q != 3'd3);
	assign pos_raddr = AW'(idx_q[cnt_q[1:0]]);

	avwn_ram #(.WIDTH(72), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// Accumulator store: {z, y, x}, 32 bits each.
	always_comb begin
		logic signed [33:0] s;
		acc_wdata = '0;
		for (int k = 0; k < 3; k++) begin
			s = 34'($signed(acc_rdata[32*k +: 32])) + 34'(d_q[k]);
			if (s > 34'sd2147483647) begin
				acc_wdata[32*k +: 32] = 32'h7fff_ffff;
			end else if (s < -34'sd2147483648) begin
				acc_wdata[32*k +: 32] = 32'h8000_0000;
			end else begin
				acc_wdata[32*k +: 32] = s[31:0];
			end
		end
		if (state_q == S_CLEAR) begin
			acc_wdata = '0;
		end
	end

	assign acc_we    = (state_q == S_CLEAR) || (state_q == S_AW);
	assign acc_waddr = (state_q == S_CLEAR) ? clr_q : AW'(idx_q[ci_q]);
	assign acc_re    = (state_q == S_AP0) || (accept && (action == ACT_READ));
	assign acc_raddr = (state_q == S_IDLE) ? AW'(vertex_index) : AW'(idx_q[ci_q]);

	avwn_ram #(.WIDTH(96), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.re    (acc_re),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (cfg_we) begin
			flip_q <= cfg_wdata;
		end
	end

	// Sequencer. Multiply steps use ph_q as issue / consume; unit steps as go / wait.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= S_IDLE;
			ph_q    <= 1'b0;
			cnt_q   <= '0;
			term_q  <= '0;
			ci_q    <= '0;
			clr_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(VERTEX_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					ph_q <= 1'b0;
					cnt_q <= '0;
					ci_q <= '0;
					if (accept) begin
						case (action)
							ACT_TRI: begin
								idx_q[0] <= corner_a;
								idx_q[1] <= corner_b;
								idx_q[2] <= corner_c;
								if (tri_ok) state_q <= S_TP;
							end
							ACT_READ: begin
								rd_idx_q <= vertex_index;
								if (32'(vertex_index) < VERTEX_DEPTH) begin
									state_q <= S_RD_WAIT;
								end else begin
									valid_q <= 1'b1;
									oidx_q  <= vertex_index;
									onx_q   <= '0;
									ony_q   <= '0;
									onz_q   <= '0;
								end
							end
							ACT_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					for (int k = 0; k < 3; k++) begin
						vec_q[k] <= 52'($signed(acc_rdata[32*k +: 32]));
					end
					frac30_q <= 1'b0;
					ret_q    <= S_RD_OUT;
					state_q  <= S_U0;
				end
				S_RD_OUT: begin
					valid_q <= 1'b1;
					oidx_q  <= rd_idx_q;
					onx_q   <= flip_q ? -uvo_q[0][15:0] : uvo_q[0][15:0];
					ony_q   <= flip_q ? -uvo_q[1][15:0] : uvo_q[1][15:0];
					onz_q   <= flip_q ? -uvo_q[2][15:0] : uvo_q[2][15:0];
					state_q <= S_IDLE;
				end
				S_TP: begin
					if (cnt_q != 3'd0) begin
						p_q[cnt_q[1:0] - 2'd1][0] <= pos_rdata[23:0];
						p_q[cnt_q[1:0] - 2'd1][1] <= pos_rdata[47:24];
						p_q[cnt_q[1:0] - 2'd1][2] <= pos_rdata[71:48];
					end
					if (cnt_q == 3'd3) begin
						cnt_q   <= '0;
						state_q <= S_TX;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_TX: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cnt_q[0]) begin
							vec_q[cnt_q[2:1]] <= vec_q[cnt_q[2:1]] - 52'(mul_q);
						end else begin
							vec_q[cnt_q[2:1]] <= 52'(mul_q);
						end
						if (cnt_q == 3'd5) begin
							cnt_q    <= '0;
							frac30_q <= 1'b0;
							ret_q    <= S_TN;
							state_q  <= S_U0;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_TN: begin
					// A zero cross product means a degenerate triangle: nothing is added.
					if (!ok_q) begin
						state_q <= S_IDLE;
					end else begin
						for (int k = 0; k < 3; k++) n_q[k] <= uvo_q[k][15:0];
						ci_q    <= '0;
						state_q <= S_CE1;
					end
				end
				S_CE1: begin
					for (int k = 0; k < 3; k++) vec_q[k] <= 52'(e1[k]);
					frac30_q <= 1'b1;
					ret_q    <= S_CE2;
					state_q  <= S_U0;
				end
				S_CE2: begin
					if (!ok_q) begin
						ang_q   <= '0;
						state_q <= S_AP0;
					end else begin
						for (int k = 0; k < 3; k++) begin
							u_q[k]   <= uvo_q[k];
							vec_q[k] <= 52'(e2[k]);
						end
						ret_q   <= S_CE3;
						state_q <= S_U0;
					end
				end
				S_CE3: begin
					if (!ok_q) begin
						ang_q   <= '0;
						state_q <= S_AP0;
					end else begin
						for (int k = 0; k < 3; k++) v_q[k] <= uvo_q[k];
						dot_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						dot_q <= dot_q + 64'(mul_q);
						if (cnt_q == 3'd2) begin
							cnt_q   <= '0;
							sq_q    <= '0;
							state_q <= S_WSQ;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_WSQ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sq_q <= sq_q + 64'(mul_q);
						if (cnt_q == 3'd2) begin
							cnt_q   <= '0;
							state_q <= S_HSQ;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_HSQ: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (arsp.done) begin
						ph_q <= 1'b0;
						// Half chord length, limited where the series still converges.
						if ((arsp.res >> 1) > 64'(H_LIMIT)) begin
							pp_q  <= 40'(H_LIMIT);
							sum_q <= 32'(H_LIMIT);
						end else begin
							pp_q  <= 40'(arsp.res >> 1);
							sum_q <= 32'(arsp.res >> 1);
						end
						state_q <= S_AX2;
					end
				end
				S_AX2: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						x2_q    <= 30'(mul_q >>> 30);
						term_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_AP;
					end
				end
				S_AP: begin
					// One series term: p*x^2, times (2n+1), over (2n+2), then p over (2n+3).
					if (!cnt_q[1]) begin
						ph_q <= !ph_q;
						if (ph_q) begin
							pp_q  <= (cnt_q == 3'd0) ? 40'(mul_q >>> 30) : 40'(mul_q);
							cnt_q <= cnt_q + 3'd1;
						end
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (arsp.done) begin
						ph_q <= 1'b0;
						if (!cnt_q[0]) begin
							pp_q  <= 40'(arsp.res);
							cnt_q <= 3'd3;
						end else begin
							sum_q <= sum_q + 32'(arsp.res);
							cnt_q <= '0;
							if (term_q == 6'(ASIN_TERMS - 1)) begin
								state_q <= S_ANG;
							end else begin
								term_q <= term_q + 6'd1;
							end
						end
					end
				end
				S_ANG: begin
					// Obtuse corners use the supplement of the chord of u+v.
					if (dot_q[63]) begin
						ang_q <= (ang_a >= 33'(PI_Q30)) ? '0 : PI_Q30 - ang_a[31:0];
					end else begin
						ang_q <= ang_a[31:0];
					end
					state_q <= S_AP0;
				end
				S_AP0: begin
					cnt_q   <= '0;
					state_q <= S_AM;
				end
				S_AM: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						d_q[cnt_q[1:0]] <= n_q[cnt_q[1:0]][15] ? -18'(q_mul) : 18'(q_mul);
						if (cnt_q == 3'd2) begin
							state_q <= S_AW;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_AW: begin
					if (ci_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= S_CE1;
					end
				end
				S_U0: begin
					ph_q  <= 1'b0;
					cnt_q <= '0;
					for (int k = 0; k < 3; k++) begin
						sgn_q[k] <= vec_q[k][51];
						mag_q[k] <= vec_q[k][51] ? 52'(-vec_q[k]) : 52'(vec_q[k]);
						uvo_q[k] <= '0;
					end
					if (vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0) begin
						ok_q    <= 1'b0;
						state_q <= ret_q;
					end else begin
						state_q <= S_USH;
					end
				end
				S_USH: begin
					// Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
					if (mmax >= 52'h4000_0000) begin
						for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
					end else if (mmax < 52'h2000_0000) begin
						for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
					end else begin
						sq_q    <= '0;
						state_q <= S_USQ;
					end
				end
				S_USQ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sq_q <= sq_q + 64'(mul_q);
						if (cnt_q == 3'd2) begin
							cnt_q   <= '0;
							state_q <= S_ULN;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_ULN: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (arsp.done) begin
						ph_q    <= 1'b0;
						len_q   <= arsp.res[31:0];
						state_q <= S_UDV;
					end
				end
				S_UDV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (arsp.done) begin
						ph_q <= 1'b0;
						uvo_q[cnt_q[1:0]] <= sgn_q[cnt_q[1:0]] ? -arsp.res[31:0] : arsp.res[31:0];
						if (cnt_q == 3'd2) begin
							ok_q    <= 1'b1;
							state_q <= ret_q;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = valid_q;
	assign out_index    = oidx_q;
	assign normal_x     = onx_q;
	assign normal_y     = ony_q;
	assign normal_z     = onz_q;

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result shown for more than a cycle");
	a_store_quick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_STORE |=> !busy) else $error("store left the block busy");
	a_unit_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		arsp.done |-> ph_q) else $error("arithmetic result arrived unawaited");
	a_acc_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_we |-> busy) else $error("accumulator written while idle");

endmodule

// ===== hdl/avwn_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module avwn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/avwn_arith.sv =====
// Shared iterative unit: 64 by 32 bit restoring divider and 64 bit integer square root.
// Uses the request and response types of avwn_pkg.
module avwn_arith
	import avwn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  arith_req_t req,
	output arith_rsp_t rsp
);

	logic        run_q;
	logic        sqrt_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;   // quotient, or remaining radicand
	logic [63:0] aux_q;   // remainder, or root
	logic [63:0] bit_q;
	logic [31:0] den_q;
	logic        done_q;

	logic [32:0] rem_sh;
	logic        ge;
	logic [63:0] trial;

	assign rem_sh = {aux_q[31:0], acc_q[63]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign trial  = aux_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q  <= 1'b1;
				sqrt_q <= req.is_sqrt;
				den_q  <= req.den;
				acc_q  <= req.num;
				aux_q  <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
				cnt_q  <= req.is_sqrt ? 6'd31 : 6'd63;
			end else if (run_q) begin
				if (sqrt_q) begin
					if (acc_q >= trial) begin
						acc_q <= acc_q - trial;
						aux_q <= (aux_q >> 1) + bit_q;
					end else begin
						aux_q <= aux_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					aux_q <= ge ? 64'(rem_sh - {1'b0, den_q}) : 64'(rem_sh);
					acc_q <= {acc_q[62:0], ge};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = sqrt_q ? aux_q : acc_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q) else $error("arith: done while still running");
	a_no_go_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !req.go) else $error("arith: new request while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("arith: done held longer than a cycle");

endmodule

// ===== bench/avwn_checker.sv =====
`timescale 1ns / 100ps
// Checker for the angle weighted vertex normal block: watches command and result beats,
// predicts every read result in fixed point and compares. Depends on avwn_pkg.
module avwn_checker
	import avwn_pkg::*;
#(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         action,
	input  logic [9:0]         vertex_index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               result_valid,
	input  logic [9:0]         out_index,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output int                 fails,
	output int                 pending
);

	typedef longint vec3_t [3];

	typedef struct {
		logic [9:0]  idx;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
	} normal_beat_t;

	localparam longint unsigned ONE_Q30 = 64'h1 << 30;

	normal_beat_t       normals_due[$];
	logic signed [23:0] vx [VERTEX_DEPTH];
	logic signed [23:0] vy [VERTEX_DEPTH];
	logic signed [23:0] vz [VERTEX_DEPTH];
	int                 sum_x [VERTEX_DEPTH];
	int                 sum_y [VERTEX_DEPTH];
	int                 sum_z [VERTEX_DEPTH];
	logic               flip;

	function automatic longint unsigned isqrt_u64(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Scales a vector to unit length with fb fraction bits; returns 0 for a zero vector.
	function automatic bit make_unit(input vec3_t c, input int fb, output vec3_t o);
		longint unsigned mag [3];
		longint unsigned m, sq, len, q;
		m = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (c[i] < 0) ? longint'(0) - c[i] : c[i];
			if (mag[i] > m) m = mag[i];
			o[i] = 0;
		end
		if (m == 0) return 0;
		while (m >= ONE_Q30) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		end
		while (m < (ONE_Q30 >> 1)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
		end
		for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
		len = isqrt_u64(sq);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << fb) + (len >> 1)) / len;
			o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint unsigned asin_series(input longint unsigned x);
		longint unsigned x2, p, total;
		if (x > H_LIMIT) x = H_LIMIT;
		p = x;
		total = x;
		x2 = (x * x) >> 30;
		for (int n = 0; n < ASIN_TERMS; n++) begin
			p = (p * x2) >> 30;
			p = p * (2 * n + 1) / (2 * n + 2);
			total = total + p / (2 * n + 3);
		end
		return total;
	endfunction

	// Angle between the edges ea and eb in Q30, using the obtuse branch when the edges point apart.
	function automatic longint unsigned corner_angle(input vec3_t ea, input vec3_t eb);
		vec3_t           u, v;
		longint          dot, w;
		longint unsigned sq, mw, a;
		dot = 0;
		sq = 0;
		if (!make_unit(ea, 30, u)) return 0;
		if (!make_unit(eb, 30, v)) return 0;
		for (int i = 0; i < 3; i++) dot = dot + u[i] * v[i];
		for (int i = 0; i < 3; i++) begin
			w = (dot < 0) ? v[i] + u[i] : v[i] - u[i];
			mw = (w < 0) ? longint'(0) - w : w;
			sq = sq + mw * mw;
		end
		a = 2 * asin_series(isqrt_u64(sq) >> 1);
		if (dot < 0) return (a >= PI_Q30) ? 0 : longint'(PI_Q30) - a;
		return a;
	endfunction

	function automatic int sat_add(input int acc, input longint inc);
		longint s;
		s = longint'(acc) + inc;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return int'(s);
	endfunction

	task automatic accumulate_triangle(input logic [9:0] ia, input logic [9:0] ib,
			input logic [9:0] ic);
		longint          p [3][3];
		int              id [3];
		vec3_t           e1, e2, cr, n;
		longint unsigned ang, mn, q;
		longint          d [3];
		int              i1, i2;
		id[0] = ia;
		id[1] = ib;
		id[2] = ic;
		for (int i = 0; i < 3; i++) begin
			if (id[i] >= VERTEX_DEPTH) return;
			p[i][0] = vx[id[i]];
			p[i][1] = vy[id[i]];
			p[i][2] = vz[id[i]];
		end
		for (int k = 0; k < 3; k++) begin
			e1[k] = p[1][k] - p[0][k];
			e2[k] = p[2][k] - p[0][k];
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		if (!make_unit(cr, 14, n)) return;
		for (int i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int k = 0; k < 3; k++) begin
				e1[k] = p[i1][k] - p[i][k];
				e2[k] = p[i2][k] - p[i][k];
			end
			ang = corner_angle(e1, e2);
			for (int k = 0; k < 3; k++) begin
				mn = (n[k] < 0) ? longint'(0) - n[k] : n[k];
				q = (mn * ang + (64'h1 << 29)) >> 30;
				d[k] = (n[k] < 0) ? -longint'(q) : longint'(q);
			end
			sum_x[id[i]] = sat_add(sum_x[id[i]], d[0]);
			sum_y[id[i]] = sat_add(sum_y[id[i]], d[1]);
			sum_z[id[i]] = sat_add(sum_z[id[i]], d[2]);
		end
	endtask

	task automatic report(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
		flip = 1'b0;
		for (int i = 0; i < VERTEX_DEPTH; i++) begin
			sum_x[i] = 0;
			sum_y[i] = 0;
			sum_z[i] = 0;
			vx[i] = '0;
			vy[i] = '0;
			vz[i] = '0;
		end
	end

	always @(posedge clk) begin
		normal_beat_t nb, got;
		vec3_t        c, n;
		if (arst_n) begin
			if (cfg_we) flip <= cfg_wdata;
			if (result_valid) begin
				got.idx = out_index;
				got.nx = normal_x;
				got.ny = normal_y;
				got.nz = normal_z;
				if (normals_due.size() == 0) begin
					report($sformatf("unexpected result for vertex %0d", out_index));
				end else begin
					nb = normals_due.pop_front();
					if (got.idx != nb.idx)
						report($sformatf("index %0d, expected %0d", got.idx, nb.idx));
					if (got.nx != nb.nx)
						report($sformatf("vertex %0d x %h, expected %h", nb.idx, got.nx, nb.nx));
					if (got.ny != nb.ny)
						report($sformatf("vertex %0d y %h, expected %h", nb.idx, got.ny, nb.ny));
					if (got.nz != nb.nz)
						report($sformatf("vertex %0d z %h, expected %h", nb.idx, got.nz, nb.nz));
				end
			end
			if (start && !busy) begin
				case (action)
					ACT_STORE: begin
						if (vertex_index < VERTEX_DEPTH) begin
							vx[vertex_index] = pos_x;
							vy[vertex_index] = pos_y;
							vz[vertex_index] = pos_z;
						end
					end
					ACT_TRI: accumulate_triangle(corner_a, corner_b, corner_c);
					ACT_READ: begin
						n[0] = 0;
						n[1] = 0;
						n[2] = 0;
						if (vertex_index < VERTEX_DEPTH) begin
							c[0] = sum_x[vertex_index];
							c[1] = sum_y[vertex_index];
							c[2] = sum_z[vertex_index];
							void'(make_unit(c, 14, n));
							if (flip) for (int k = 0; k < 3; k++) n[k] = -n[k];
						end
						nb.idx = vertex_index;
						nb.nx = n[0][15:0];
						nb.ny = n[1][15:0];
						nb.nz = n[2][15:0];
						normals_due.insert(normals_due.size(), nb);
					end
					default: begin
						for (int i = 0; i < VERTEX_DEPTH; i++) begin
							sum_x[i] = 0;
							sum_y[i] = 0;
							sum_z[i] = 0;
						end
					end
				endcase
			end
			pending <= normals_due.size();
		end
	end

endmodule

// ===== bench/angle_weighted_vertex_normals_tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for angle_weighted_vertex_normals: clock, reset, command stimulus,
// flip register phases, watchdog and verdict. Depends on avwn_pkg and avwn_checker.
module angle_weighted_vertex_normals_tb
	import avwn_pkg::*;
();

	localparam int DEPTH       = 1024;
	localparam int PHASE_BEATS = 440;
	localparam int STALL_LIMIT = 200000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [9:0]         vertex_index;
	logic signed [23:0] pos_x, pos_y, pos_z;
	logic [9:0]         corner_a, corner_b, corner_c;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               result_valid;
	logic [9:0]         out_index;
	logic signed [15:0] normal_x, normal_y, normal_z;
	int                 fails;
	int                 pending;
	int                 quiet_cycles;
	int                 beat_count;
	int                 stored_list[$];
	bit                 stored [DEPTH];

	angle_weighted_vertex_normals #(.VERTEX_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .vertex_index(vertex_index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .out_index(out_index),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	avwn_checker #(.VERTEX_DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .vertex_index(vertex_index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .out_index(out_index),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// The watchdog counts cycles in which no beat moves on either side. A full triangle
	// is the longest silent stretch, so the limit is generous.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Presents one command beat from the falling edge and holds it until the block takes
	// it. Busy only moves at rising edges, so its level here is the one the next edge sees.
	// Every field that the action does not use carries random content, so that all bits
	// of every port are exercised.
	task automatic send_beat(input logic [1:0] act, input int vi,
			input int px, input int py, input int pz, input int ca, input int cb, input int cc);
		@(negedge clk);
		start = 1'b1;
		action = act;
		vertex_index = (act == ACT_STORE || act == ACT_READ) ? vi[9:0] : 10'($urandom);
		pos_x = (act == ACT_STORE) ? px[23:0] : 24'($urandom);
		pos_y = (act == ACT_STORE) ? py[23:0] : 24'($urandom);
		pos_z = (act == ACT_STORE) ? pz[23:0] : 24'($urandom);
		corner_a = (act == ACT_TRI) ? ca[9:0] : 10'($urandom);
		corner_b = (act == ACT_TRI) ? cb[9:0] : 10'($urandom);
		corner_c = (act == ACT_TRI) ? cc[9:0] : 10'($urandom);
		while (busy) @(negedge clk);
		@(posedge clk);
		if (act == ACT_STORE && !stored[vi]) begin
			stored[vi] = 1'b1;
			stored_list.insert(stored_list.size(), vi);
		end
		beat_count++;
	endtask

	task automatic idle_gap(input bit allowed);
		if (allowed && $urandom_range(0, 99) < 14) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// The flip register is only written once every read has been answered and the block
	// has dropped busy, so no command is in flight when it changes.
	task automatic write_flip(input logic value);
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic int pick_stored();
		return stored_list[$urandom_range(0, stored_list.size() - 1)];
	endfunction

	function automatic int rand_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8388607;
		if (r == 1) return -8388608;
		if (r < 5) return int'($urandom_range(0, 65535 * 8)) - 65535 * 4;
		return int'($urandom);
	endfunction

	// One random command. Most are well formed: stores, reads of written or random
	// vertices, triangles over distinct written corners, and clears. A small share are broken
	// triangles with a repeated corner, which the block must skip.
	task automatic random_beat();
		int r, a, b, c;
		r = $urandom_range(0, 999);
		if (r < 450 || stored_list.size() < 3) begin
			send_beat(ACT_STORE, $urandom_range(0, DEPTH - 1),
				rand_pos(), rand_pos(), rand_pos(), 0, 0, 0);
		end else if (r < 870) begin
			send_beat(ACT_READ, (r & 1) ? pick_stored() : $urandom_range(0, DEPTH - 1),
				0, 0, 0, 0, 0, 0);
		end else if (r < 890) begin
			a = pick_stored();
			do b = pick_stored(); while (b == a);
			do c = pick_stored(); while (c == a || c == b);
			send_beat(ACT_TRI, 0, 0, 0, 0, a, b, c);
		end else if (r < 895) begin
			send_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		end else begin
			a = pick_stored();
			b = pick_stored();
			send_beat(ACT_TRI, 0, 0, 0, 0, a, b, (r & 1) ? a : b);
		end
	endtask

	initial begin
		quiet_cycles = 0;
		beat_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_STORE;
		vertex_index = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		corner_a = '0;
		corner_b = '0;
		corner_c = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The clearing sweep after reset holds busy high; write_flip waits it out.
		write_flip(1'b0);

		// Directed part: a unit right triangle, the extreme corners of the position range,
		// an obtuse corner, a repeated corner, collinear corners and two vertices at one
		// place, reads of touched and untouched vertices, and a clear.
		send_beat(ACT_STORE, 0, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_STORE, 1, 65536, 0, 0, 0, 0, 0);
		send_beat(ACT_STORE, 2, 0, 65536, 0, 0, 0, 0);
		send_beat(ACT_STORE, 1023, 8388607, 8388607, 8388607, 0, 0, 0);
		send_beat(ACT_STORE, 1022, -8388608, -8388608, -8388608, 0, 0, 0);
		send_beat(ACT_STORE, 1021, 8388607, -8388608, 0, 0, 0, 0);
		send_beat(ACT_STORE, 3, -3 * 65536, 16384, 0, 0, 0, 0);
		send_beat(ACT_STORE, 4, 2 * 65536, 0, 0, 0, 0, 0);
		send_beat(ACT_STORE, 5, 65536, 0, 0, 0, 0, 0);
		send_beat(ACT_TRI, 0, 0, 0, 0, 0, 1, 2);
		send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_READ, 1, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_READ, 2, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_TRI, 0, 0, 0, 0, 1023, 1022, 1021);
		send_beat(ACT_READ, 1023, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_TRI, 0, 0, 0, 0, 0, 1, 3);
		send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_TRI, 0, 0, 0, 0, 0, 0, 1);
		send_beat(ACT_TRI, 0, 0, 0, 0, 0, 1, 4);
		send_beat(ACT_TRI, 0, 0, 0, 0, 1, 5, 2);
		send_beat(ACT_READ, 500, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 0);

		// Random part in four phases with the flip register alternating. Part of the
		// second phase runs with no idle gaps at all.
		for (int ph = 0; ph < 4; ph++) begin
			write_flip((ph % 2) == 0);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				random_beat();
				idle_gap(!(ph == 1 && i >= 100 && i < 400));
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
